// ===== design/lkc_pkg.sv =====
// Package: types, constants and lookup functions for the LED/key controller I2C master.
package lkc_pkg;

    localparam int unsigned DIGIT_COUNT = 8;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_DELAY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT  = 8'd1;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_RAW      = 3'd1;
    localparam logic [2:0] CMD_DIGIT    = 3'd2;
    localparam logic [2:0] CMD_SEGMENTS = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;
    localparam logic [2:0] CMD_KEY_READ = 3'd5;
    localparam logic [2:0] CMD_INIT     = 3'd6;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    localparam logic [7:0] WRITE_BASE     = 8'h60;
    localparam logic [7:0] READ_ADDR      = 8'h6F;
    localparam logic [7:0] POINT_MASK     = 8'h80;
    localparam logic [3:0] DIGIT_REG_BASE = 4'h8;
    localparam logic [3:0] INIT_CMD_A     = 4'h7;
    localparam logic [3:0] INIT_CMD_B     = 4'h4;
    localparam logic [7:0] INIT_DATA_B    = 8'h03;
    localparam logic [4:0] KEY_NONE       = 5'd16;
    localparam logic [7:0] ACK_SAT        = 8'd255;

    typedef enum logic [15:0] {
        PH_IDLE = 16'h0001,
        PH_ST1  = 16'h0002,
        PH_ST2  = 16'h0004,
        PH_ST3  = 16'h0008,
        PH_TXD  = 16'h0010,
        PH_TXH  = 16'h0020,
        PH_TXL  = 16'h0040,
        PH_AKR  = 16'h0080,
        PH_AKH  = 16'h0100,
        PH_AKP  = 16'h0200,
        PH_AKL  = 16'h0400,
        PH_RXH  = 16'h0800,
        PH_RXL  = 16'h1000,
        PH_SP1  = 16'h2000,
        PH_SP2  = 16'h4000,
        PH_FIN  = 16'h8000
    } phase_t;

    typedef enum logic [1:0] {
        JOB_ONE   = 2'd0,
        JOB_CLEAR = 2'd1,
        JOB_INIT  = 2'd2,
        JOB_READ  = 2'd3
    } job_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] delay;
        logic [2:0] bit_idx;
        logic [7:0] shift;
        logic [7:0] pend;
        logic [2:0] wcnt;
        logic [7:0] ack;
        logic       scl;
        logic       sda;
        logic [4:0] last_key;
        job_t       job;
        logic       stage;
    } lkc_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [4:0] key_code;
        logic       key_valid;
        logic       rejected;
    } lkc_result_t;

    localparam lkc_state_t STATE_RESET = '{
        phase: PH_IDLE, delay: 8'd0, bit_idx: 3'd0, shift: 8'd0, pend: 8'd0,
        wcnt: 3'd0, ack: 8'd0, scl: 1'b1, sda: 1'b1, last_key: KEY_NONE,
        job: JOB_ONE, stage: 1'b0
    };

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'h0: r = 8'h3F;
            4'h1: r = 8'h06;
            4'h2: r = 8'h5B;
            4'h3: r = 8'h4F;
            4'h4: r = 8'h66;
            4'h5: r = 8'h6D;
            4'h6: r = 8'h7D;
            4'h7: r = 8'h07;
            4'h8: r = 8'h7F;
            4'h9: r = 8'h6F;
            4'hA: r = 8'h77;
            4'hB: r = 8'h7C;
            4'hC: r = 8'h39;
            4'hD: r = 8'h5E;
            4'hE: r = 8'h79;
            default: r = 8'h71;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] decode_key(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h4A: k = 5'd0;
            8'h47: k = 5'd1;
            8'h46: k = 5'd2;
            8'h45: k = 5'd3;
            8'h43: k = 5'd4;
            8'h42: k = 5'd5;
            8'h41: k = 5'd6;
            8'h4F: k = 5'd7;
            8'h4E: k = 5'd8;
            8'h4D: k = 5'd9;
            8'h44: k = 5'd10;
            8'h40: k = 5'd11;
            8'h4C: k = 5'd12;
            8'h48: k = 5'd13;
            8'h4B: k = 5'd14;
            8'h49: k = 5'd15;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] write_addr(input logic [3:0] cmd);
        return WRITE_BASE | {3'b000, cmd, 1'b0};
    endfunction

endpackage

// ===== design/lkc_if.sv =====
// Interfaces: request, result and configuration channels.
interface lkc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [3:0] cmd_nibble;
    logic [7:0] payload;
    logic [2:0] position;
    logic       sda_sample;

    modport source (output valid, output command, output cmd_nibble, output payload,
                    output position, output sda_sample, input ready);
    modport sink (input valid, input command, input cmd_nibble, input payload,
                  input position, input sda_sample, output ready);
endinterface

interface lkc_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [4:0] key_code;
    logic       key_valid;
    logic       rejected;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output key_code, output key_valid, output rejected,
                    input ready);
    modport sink (input valid, input scl_level, input sda_level, input busy_res,
                  input done_res, input key_code, input key_valid, input rejected,
                  output ready);
endinterface

interface lkc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lkc_pkg::CFG_INDEX_W-1:0]  index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/lkc_step.sv =====
// Single-tick sequencer step: next state and result for one request.
module lkc_step (
    input  logic [7:0]          ticks_per_delay,
    input  logic [7:0]          ack_poll_limit,
    input  logic [2:0]          command,
    input  logic [3:0]          cmd_nibble,
    input  logic [7:0]          payload,
    input  logic [2:0]          position,
    input  logic                sda_sample,
    input  lkc_pkg::lkc_state_t state_cur,
    output lkc_pkg::lkc_state_t state_next,
    output lkc_pkg::lkc_result_t result
);

    // start condition: begin_write plus the first START step
    function automatic lkc_pkg::lkc_state_t start_seq(input lkc_pkg::lkc_state_t s,
                                                       input logic [7:0] first,
                                                       input logic [7:0] tm1);
        lkc_pkg::lkc_state_t r;
        r         = s;
        r.shift   = first;
        r.stage   = 1'b0;
        r.bit_idx = 3'd0;
        r.sda     = 1'b1;
        r.scl     = 1'b1;
        r.phase   = lkc_pkg::PH_ST2;
        r.delay   = tm1;
        return r;
    endfunction

    function automatic lkc_pkg::lkc_state_t ack_low(input lkc_pkg::lkc_state_t s,
                                                     input logic [7:0] tm1);
        lkc_pkg::lkc_state_t r;
        r       = s;
        r.scl   = 1'b0;
        r.delay = tm1;
        r.bit_idx = 3'd0;
        if (s.job == lkc_pkg::JOB_READ)
        begin
            r.shift = 8'd0;
            r.phase = lkc_pkg::PH_RXH;
        end
        else if (!s.stage)
        begin
            r.stage = 1'b1;
            r.shift = s.pend;
            r.phase = lkc_pkg::PH_TXD;
        end
        else
        begin
            r.bit_idx = s.bit_idx;
            r.phase   = lkc_pkg::PH_SP1;
        end
        return r;
    endfunction

    always_comb
    begin
        lkc_pkg::lkc_state_t s;
        logic [7:0] tm1;
        logic [7:0] lim;
        logic [7:0] ack_inc;
        logic [3:0] digit_reg;
        logic [3:0] wcnt_inc;
        logic       request;
        logic       run;
        logic       done;
        logic       kv;
        logic       rej;

        tm1       = (ticks_per_delay == 8'd0) ? 8'd0 : ticks_per_delay - 8'd1;
        lim       = (ack_poll_limit == 8'd0) ? 8'd1 : ack_poll_limit;
        digit_reg = {1'b1, 3'(3'd3 - position)};
        wcnt_inc  = {1'b0, state_cur.wcnt} + 4'd1;
        request   = (command != lkc_pkg::CMD_TICK) && (command != lkc_pkg::CMD_UNUSED);
        s         = state_cur;
        run       = 1'b0;
        done      = 1'b0;
        kv        = 1'b0;
        rej       = 1'b0;
        ack_inc   = 8'd0;

        if (state_cur.phase != lkc_pkg::PH_IDLE)
        begin
            rej = request;
            if (state_cur.delay != 8'd0)
                s.delay = state_cur.delay - 8'd1;
            else
                run = 1'b1;
        end
        else if (request)
        begin
            s.wcnt = 3'd0;
            s.job  = lkc_pkg::JOB_ONE;
            case (command)
                lkc_pkg::CMD_RAW:
                begin
                    s.pend = payload;
                    s = start_seq(s, lkc_pkg::write_addr(cmd_nibble), tm1);
                end
                lkc_pkg::CMD_DIGIT:
                begin
                    s.pend = lkc_pkg::seg_font(payload[3:0]) | (payload & lkc_pkg::POINT_MASK);
                    s = start_seq(s, lkc_pkg::write_addr(digit_reg), tm1);
                end
                lkc_pkg::CMD_SEGMENTS:
                begin
                    s.pend = payload;
                    s = start_seq(s, lkc_pkg::write_addr(digit_reg), tm1);
                end
                lkc_pkg::CMD_CLEAR:
                begin
                    s.job  = lkc_pkg::JOB_CLEAR;
                    s.pend = 8'd0;
                    s = start_seq(s, lkc_pkg::write_addr(lkc_pkg::DIGIT_REG_BASE), tm1);
                end
                lkc_pkg::CMD_KEY_READ:
                begin
                    s.job = lkc_pkg::JOB_READ;
                    s = start_seq(s, lkc_pkg::READ_ADDR, tm1);
                end
                default:
                begin
                    s.job  = lkc_pkg::JOB_INIT;
                    s.pend = 8'd0;
                    s = start_seq(s, lkc_pkg::write_addr(lkc_pkg::INIT_CMD_A), tm1);
                end
            endcase
        end

        if (run)
        begin
            unique case (state_cur.phase)
                lkc_pkg::PH_ST1:
                begin
                    s.sda = 1'b1; s.scl = 1'b1;
                    s.phase = lkc_pkg::PH_ST2; s.delay = tm1;
                end
                lkc_pkg::PH_ST2:
                begin
                    s.sda = 1'b0;
                    s.phase = lkc_pkg::PH_ST3; s.delay = tm1;
                end
                lkc_pkg::PH_ST3:
                begin
                    s.scl = 1'b0;
                    s.phase = lkc_pkg::PH_TXD; s.delay = tm1;
                end
                lkc_pkg::PH_TXD:
                begin
                    s.sda = state_cur.shift[7];
                    s.phase = lkc_pkg::PH_TXH; s.delay = tm1;
                end
                lkc_pkg::PH_TXH:
                begin
                    s.scl = 1'b1;
                    s.phase = lkc_pkg::PH_TXL; s.delay = tm1;
                end
                lkc_pkg::PH_TXL:
                begin
                    s.scl   = 1'b0;
                    s.shift = {state_cur.shift[6:0], 1'b0};
                    s.delay = tm1;
                    if (state_cur.bit_idx == 3'd7)
                    begin
                        s.bit_idx = 3'd0;
                        s.phase   = lkc_pkg::PH_AKR;
                    end
                    else
                    begin
                        s.bit_idx = state_cur.bit_idx + 3'd1;
                        s.phase   = lkc_pkg::PH_TXD;
                    end
                end
                lkc_pkg::PH_AKR:
                begin
                    s.sda = 1'b1;
                    s.phase = lkc_pkg::PH_AKH; s.delay = tm1;
                end
                lkc_pkg::PH_AKH:
                begin
                    s.scl = 1'b1; s.ack = 8'd0;
                    s.phase = lkc_pkg::PH_AKP; s.delay = tm1;
                end
                lkc_pkg::PH_AKP:
                begin
                    if (!sda_sample)
                        s = ack_low(state_cur, tm1);
                    else
                    begin
                        ack_inc = (state_cur.ack != lkc_pkg::ACK_SAT) ?
                                  state_cur.ack + 8'd1 : state_cur.ack;
                        s.ack   = ack_inc;
                        s.delay = tm1;
                        s.phase = (ack_inc >= lim) ? lkc_pkg::PH_AKL : lkc_pkg::PH_AKP;
                    end
                end
                lkc_pkg::PH_AKL:
                    s = ack_low(state_cur, tm1);
                lkc_pkg::PH_RXH:
                begin
                    s.sda = 1'b1; s.scl = 1'b1;
                    s.phase = lkc_pkg::PH_RXL; s.delay = tm1;
                end
                lkc_pkg::PH_RXL:
                begin
                    s.shift = {state_cur.shift[6:0], sda_sample};
                    s.scl   = 1'b0;
                    s.delay = tm1;
                    if (state_cur.bit_idx == 3'd7)
                    begin
                        s.bit_idx = 3'd0;
                        s.phase   = lkc_pkg::PH_SP1;
                    end
                    else
                    begin
                        s.bit_idx = state_cur.bit_idx + 3'd1;
                        s.phase   = lkc_pkg::PH_RXH;
                    end
                end
                lkc_pkg::PH_SP1:
                begin
                    s.sda = 1'b0; s.scl = 1'b1;
                    s.phase = lkc_pkg::PH_SP2; s.delay = tm1;
                end
                lkc_pkg::PH_SP2:
                begin
                    s.sda = 1'b1;
                    s.phase = lkc_pkg::PH_FIN; s.delay = tm1;
                end
                lkc_pkg::PH_FIN:
                begin
                    if (state_cur.job == lkc_pkg::JOB_CLEAR &&
                        wcnt_inc < 4'(lkc_pkg::DIGIT_COUNT))
                    begin
                        s.wcnt = wcnt_inc[2:0];
                        s.pend = 8'd0;
                        s = start_seq(s, lkc_pkg::write_addr({1'b1, wcnt_inc[2:0]}), tm1);
                    end
                    else if (state_cur.job == lkc_pkg::JOB_INIT && state_cur.wcnt == 3'd0)
                    begin
                        s.wcnt = 3'd1;
                        s.pend = lkc_pkg::INIT_DATA_B;
                        s = start_seq(s, lkc_pkg::write_addr(lkc_pkg::INIT_CMD_B), tm1);
                    end
                    else
                    begin
                        if (state_cur.job == lkc_pkg::JOB_READ)
                        begin
                            s.last_key = lkc_pkg::decode_key(state_cur.shift);
                            kv = 1'b1;
                        end
                        done    = 1'b1;
                        s.phase = lkc_pkg::PH_IDLE;
                        s.delay = 8'd0;
                    end
                end
                default:
                begin
                    s.phase = lkc_pkg::PH_IDLE;
                    s.delay = 8'd0;
                end
            endcase
        end

        state_next       = s;
        result.scl_level = s.scl;
        result.sda_level = s.sda;
        result.busy_res  = (s.phase != lkc_pkg::PH_IDLE);
        result.done_res  = done;
        result.key_code  = s.last_key;
        result.key_valid = kv;
        result.rejected  = rej;
    end

endmodule

// ===== design/led_key_controller_i2c_master_top.sv =====
// Top level: LED/key controller I2C master with request, result and config channels.
// A result is registered and is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while res.ready is high; the result register frees in the same cycle it is taken.
// Each request advances the pin sequencer by one tick.
// Reset (rst_n low, async): idle, pins released high, key 16, delay slot 1 tick, poll limit 250.
module led_key_controller_i2c_master_top (
    input  logic  clk,
    input  logic  rst_n,
    lkc_req_if.sink   req,
    lkc_res_if.source res,
    lkc_cfg_if.sink   cfg
);

    lkc_pkg::lkc_state_t  state_reg;
    lkc_pkg::lkc_state_t  state_next;
    lkc_pkg::lkc_result_t result_next;
    lkc_pkg::lkc_result_t result_reg;
    logic                 out_valid_reg;
    logic [7:0]           ticks_reg;
    logic [7:0]           limit_reg;
    logic                 accept;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    lkc_step u_step (
        .ticks_per_delay (ticks_reg),
        .ack_poll_limit  (limit_reg),
        .command         (req.command),
        .cmd_nibble      (req.cmd_nibble),
        .payload         (req.payload),
        .position        (req.position),
        .sda_sample      (req.sda_sample),
        .state_cur       (state_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= 8'd1;
            limit_reg <= 8'd250;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lkc_pkg::CFG_TICKS_PER_DELAY: ticks_reg <= cfg.data;
                lkc_pkg::CFG_ACK_POLL_LIMIT:  limit_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkc_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_level = result_reg.scl_level;
    assign res.sda_level = result_reg.sda_level;
    assign res.busy_res  = result_reg.busy_res;
    assign res.done_res  = result_reg.done_res;
    assign res.key_code  = result_reg.key_code;
    assign res.key_valid = result_reg.key_valid;
    assign res.rejected  = result_reg.rejected;

    // key read end is always a sequence end
    a_kv_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.key_valid |-> res.done_res)
        else $error("key_valid without done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> !res.busy_res)
        else $error("done while busy");

    a_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == lkc_pkg::PH_IDLE |-> state_reg.delay == 8'd0)
        else $error("idle with pending delay");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(result_reg))
        else $error("result lost under stall");

    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule
